/* design/gbl_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbl_pkg
// Shared constants, codes and controller/datapath bundles of the greedy
// best-link path selector.
// ----------------------------------------------------------------------------
package gbl_pkg;

    localparam int MAX_NODES = 16;
    localparam int NODE_W    = $clog2(MAX_NODES);
    localparam int CNT_W     = NODE_W + 1;
    localparam int TAB_DEPTH = MAX_NODES * MAX_NODES;
    localparam int ADDR_W    = 2 * NODE_W;
    localparam int WEIGHT_W  = 16;
    localparam int PATH_W    = 8;
    localparam int STATUS_W  = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 5;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 24;

    localparam logic [NODE_W-1:0] HOP_LIMIT = NODE_W'(15);

    // result status codes
    localparam logic [STATUS_W-1:0] ST_HOP    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_WACK   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOMORE = 2'd2;

    // config register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SINK       = 2'd2;

    localparam logic [CNT_W-1:0]  RST_NODE_COUNT = CNT_W'(16);
    localparam logic [NODE_W-1:0] RST_SOURCE     = NODE_W'(0);
    localparam logic [NODE_W-1:0] RST_SINK       = NODE_W'(1);

    // result select codes
    localparam logic [2:0] RES_WACK   = 3'd0;
    localparam logic [2:0] RES_NOMORE = 3'd1;
    localparam logic [2:0] RES_SELF   = 3'd2;
    localparam logic [2:0] RES_DIRECT = 3'd3;
    localparam logic [2:0] RES_HOP    = 3'd4;

    typedef struct packed {
        logic       accept;
        logic       wr;
        logic       start;
        logic       rd_dir;
        logic       mark_cur;
        logic       scan_start;
        logic       scan_run;
        logic       load;
        logic [2:0] res_sel;
        logic       set_exh;
        logic       path_inc;
        logic       hop_adv;
    } t_cmd;

    typedef struct packed {
        logic early_fail;
        logic self_path;
        logic first;
        logic hop_limit;
        logic dir_hit;
        logic scan_done;
        logic best_none;
        logic hop_last;
        logic out_free;
    } t_sts;

endpackage

/* design/gbl_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbl_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module gbl_ram #(
    parameter int DATA_W = 16,
    parameter int DEPTH  = 256,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* design/gbl_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbl_dp
// Datapath: config registers, link table, used marks, neighbour scan,
// walk position and the output register.
// ----------------------------------------------------------------------------
module gbl_dp (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  gbl_pkg::t_cmd                   i_cmd,
    output gbl_pkg::t_sts                   o_sts,
    input  logic [gbl_pkg::NODE_W-1:0]      i_row_node,
    input  logic [gbl_pkg::NODE_W-1:0]      i_col_node,
    input  logic [gbl_pkg::WEIGHT_W-1:0]    i_weight,
    input  logic                            i_cfg_valid,
    input  logic [gbl_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [gbl_pkg::CFG_DAT_W-1:0]   i_cfg_data,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [gbl_pkg::OUT_DATA_W-1:0]  o_m_tdata,
    output logic                            o_m_tlast
);
    import gbl_pkg::*;

    logic [CNT_W-1:0]    r_node_count;
    logic [NODE_W-1:0]   r_src;
    logic [NODE_W-1:0]   r_snk;
    logic [TAB_DEPTH-1:0] r_valid;
    logic [MAX_NODES-1:0] r_marks;
    logic [PATH_W-1:0]   r_path;
    logic                r_exh;
    logic [NODE_W-1:0]   r_cur;
    logic                r_first;
    logic [NODE_W-1:0]   r_hopcnt;
    logic [NODE_W-1:0]   r_row;
    logic [NODE_W-1:0]   r_col;
    logic [CNT_W-1:0]    r_scan_idx;
    logic                r_pipe_vld;
    logic [NODE_W-1:0]   r_pipe_idx;
    logic [WEIGHT_W-1:0] r_top;
    logic [NODE_W-1:0]   r_best;
    logic                r_best_vld;
    logic                r_rd_vld;
    logic                r_out_vld;
    logic [STATUS_W-1:0] r_out_status;
    logic [NODE_W-1:0]   r_out_from;
    logic [NODE_W-1:0]   r_out_to;
    logic [PATH_W-1:0]   r_out_path;
    logic                r_out_last;

    logic [CNT_W-1:0]    n_eff;
    logic                scan_issue;
    logic                ram_re;
    logic [ADDR_W-1:0]   ram_raddr;
    logic [WEIGHT_W-1:0] ram_rdata;
    logic [WEIGHT_W-1:0] w_rd;
    logic                cand;
    logic                hop_last;
    logic                out_free;
    logic [STATUS_W-1:0] res_status;
    logic [NODE_W-1:0]   res_from;
    logic [NODE_W-1:0]   res_to;
    logic                res_last;

    assign n_eff      = (r_node_count > CNT_W'(MAX_NODES)) ? CNT_W'(MAX_NODES) : r_node_count;
    assign scan_issue = r_scan_idx < n_eff;
    assign ram_re     = i_cmd.rd_dir || (i_cmd.scan_run && scan_issue);
    assign ram_raddr  = i_cmd.rd_dir ? {r_cur, r_src} : {r_cur, r_scan_idx[NODE_W-1:0]};
    assign w_rd       = r_rd_vld ? ram_rdata : '0;
    assign cand       = r_pipe_vld && (w_rd != '0) && !r_marks[r_pipe_idx] && (w_rd > r_top);
    assign hop_last   = !r_first && (r_best == r_src);
    assign out_free   = !r_out_vld || i_m_tready;

    gbl_ram #(
        .DATA_W (WEIGHT_W),
        .DEPTH  (TAB_DEPTH)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wr),
        .i_waddr ({i_row_node, i_col_node}),
        .i_wdata (i_weight),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        o_sts.early_fail = r_exh || ({1'b0, r_src} >= n_eff) || ({1'b0, r_snk} >= n_eff);
        o_sts.self_path  = (r_src == r_snk);
        o_sts.first      = r_first;
        o_sts.hop_limit  = (r_hopcnt == HOP_LIMIT);
        o_sts.dir_hit    = (w_rd != '0);
        o_sts.scan_done  = !scan_issue && !r_pipe_vld;
        o_sts.best_none  = !r_best_vld;
        o_sts.hop_last   = hop_last;
        o_sts.out_free   = out_free;
    end

    always_comb begin
        res_status = ST_HOP;
        res_from   = '0;
        res_to     = '0;
        res_last   = 1'b1;
        unique case (i_cmd.res_sel)
            RES_WACK: begin
                res_status = ST_WACK;
                res_from   = r_row;
                res_to     = r_col;
            end
            RES_NOMORE: begin
                res_status = ST_NOMORE;
            end
            RES_SELF: begin
                res_from = r_src;
                res_to   = r_src;
            end
            RES_DIRECT: begin
                res_from = r_cur;
                res_to   = r_src;
            end
            RES_HOP: begin
                res_from = r_cur;
                res_to   = r_best;
                res_last = hop_last;
            end
            default: begin
                res_status = ST_NOMORE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= RST_NODE_COUNT;
            r_src        <= RST_SOURCE;
            r_snk        <= RST_SINK;
            r_valid      <= '0;
            r_marks      <= '0;
            r_path       <= '0;
            r_exh        <= 1'b0;
            r_scan_idx   <= '0;
            r_pipe_vld   <= 1'b0;
            r_best_vld   <= 1'b0;
            r_rd_vld     <= 1'b0;
            r_out_vld    <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_NODE_COUNT: r_node_count <= i_cfg_data;
                    CFG_SOURCE:     r_src        <= i_cfg_data[NODE_W-1:0];
                    CFG_SINK:       r_snk        <= i_cfg_data[NODE_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.wr) begin
                r_valid[{i_row_node, i_col_node}] <= 1'b1;
            end
            if (ram_re) begin
                r_rd_vld <= r_valid[ram_raddr];
            end
            if (i_cmd.mark_cur) begin
                r_marks[r_cur] <= 1'b1;
            end
            if (i_cmd.hop_adv && (r_best != r_src)) begin
                r_marks[r_best] <= 1'b1;
            end
            if (i_cmd.path_inc) begin
                r_path <= r_path + PATH_W'(1);
            end
            if (i_cmd.set_exh) begin
                r_exh <= 1'b1;
            end
            if (i_cmd.scan_start) begin
                r_scan_idx <= '0;
                r_pipe_vld <= 1'b0;
                r_best_vld <= 1'b0;
            end else if (i_cmd.scan_run) begin
                r_pipe_vld <= scan_issue;
                if (scan_issue) begin
                    r_scan_idx <= r_scan_idx + CNT_W'(1);
                end
                if (cand) begin
                    r_best_vld <= 1'b1;
                end
            end
            if (i_cmd.load) begin
                r_out_vld <= 1'b1;
            end else if (i_m_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // walk and payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_row <= i_row_node;
            r_col <= i_col_node;
        end
        if (i_cmd.start) begin
            r_cur    <= r_snk;
            r_first  <= !r_marks[r_snk];
            r_hopcnt <= '0;
        end else if (i_cmd.hop_adv) begin
            r_cur    <= r_best;
            r_hopcnt <= r_hopcnt + NODE_W'(1);
        end
        if (i_cmd.scan_start) begin
            r_top <= '0;
        end else if (i_cmd.scan_run) begin
            if (scan_issue) begin
                r_pipe_idx <= r_scan_idx[NODE_W-1:0];
            end
            if (cand) begin
                r_top  <= w_rd;
                r_best <= r_pipe_idx;
            end
        end
        if (i_cmd.load) begin
            r_out_status <= res_status;
            r_out_from   <= res_from;
            r_out_to     <= res_to;
            r_out_path   <= r_path;
            r_out_last   <= res_last;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {(OUT_DATA_W - STATUS_W - 2 * NODE_W - PATH_W)'(0),
                         r_out_path, r_out_to, r_out_from, r_out_status};
    assign o_m_tlast  = r_out_last;

endmodule

/* design/gbl_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbl_ctrl
// Controller: sequences write acknowledges, the start checks and the
// hop-by-hop greedy walk over the datapath.
// ----------------------------------------------------------------------------
module gbl_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_tvalid,
    output logic          o_s_tready,
    input  logic          i_func,
    input  gbl_pkg::t_sts i_sts,
    output gbl_pkg::t_cmd o_cmd
);
    import gbl_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_WACK   = 3'd1;
    localparam logic [2:0] S_CHECK  = 3'd2;
    localparam logic [2:0] S_STEP   = 3'd3;
    localparam logic [2:0] S_DIRRD  = 3'd4;
    localparam logic [2:0] S_DIRCHK = 3'd5;
    localparam logic [2:0] S_SCAN   = 3'd6;
    localparam logic [2:0] S_RES    = 3'd7;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.res_sel = RES_NOMORE;
        o_s_tready = (r_state == S_IDLE);
        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.accept = 1'b1;
                    o_cmd.wr     = !i_func;
                    n_state      = i_func ? S_CHECK : S_WACK;
                end
            end
            S_WACK: begin
                if (i_sts.out_free) begin
                    o_cmd.load    = 1'b1;
                    o_cmd.res_sel = RES_WACK;
                    n_state       = S_IDLE;
                end
            end
            S_CHECK: begin
                if (i_sts.early_fail) begin
                    if (i_sts.out_free) begin
                        o_cmd.load    = 1'b1;
                        o_cmd.res_sel = RES_NOMORE;
                        n_state       = S_IDLE;
                    end
                end else if (i_sts.self_path) begin
                    if (i_sts.out_free) begin
                        o_cmd.load     = 1'b1;
                        o_cmd.res_sel  = RES_SELF;
                        o_cmd.path_inc = 1'b1;
                        n_state        = S_IDLE;
                    end
                end else begin
                    o_cmd.start = 1'b1;
                    n_state     = S_STEP;
                end
            end
            S_STEP: begin
                if (i_sts.hop_limit) begin
                    if (i_sts.out_free) begin
                        o_cmd.load    = 1'b1;
                        o_cmd.res_sel = RES_NOMORE;
                        o_cmd.set_exh = 1'b1;
                        n_state       = S_IDLE;
                    end
                end else if (i_sts.first) begin
                    n_state = S_DIRRD;
                end else begin
                    o_cmd.scan_start = 1'b1;
                    n_state          = S_SCAN;
                end
            end
            S_DIRRD: begin
                o_cmd.rd_dir = 1'b1;
                n_state      = S_DIRCHK;
            end
            S_DIRCHK: begin
                if (i_sts.dir_hit) begin
                    if (i_sts.out_free) begin
                        o_cmd.load     = 1'b1;
                        o_cmd.res_sel  = RES_DIRECT;
                        o_cmd.path_inc = 1'b1;
                        n_state        = S_IDLE;
                    end
                end else begin
                    o_cmd.mark_cur   = 1'b1;
                    o_cmd.scan_start = 1'b1;
                    n_state          = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_sts.scan_done) begin
                    n_state = S_RES;
                end else begin
                    o_cmd.scan_run = 1'b1;
                end
            end
            S_RES: begin
                if (i_sts.out_free) begin
                    o_cmd.load = 1'b1;
                    if (i_sts.best_none) begin
                        o_cmd.res_sel = RES_NOMORE;
                        o_cmd.set_exh = 1'b1;
                        n_state       = S_IDLE;
                    end else begin
                        o_cmd.res_sel  = RES_HOP;
                        o_cmd.hop_adv  = 1'b1;
                        o_cmd.path_inc = i_sts.hop_last;
                        n_state        = i_sts.hop_last ? S_IDLE : S_STEP;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

/* design/greedy_best_link_path_select.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// greedy_best_link_path_select
// Link-weight table with a greedy best-link walk from sink toward source.
//
// Input items (s side): tuser selects a weight write (0) or a path request (1).
// A write stores one 8.8 weight; its acknowledge is loaded into the output
// register once that register is free, and only then is the next item taken.
// A path request returns one item per hop, tlast on the final one, or a
// no-more-paths item once the walk dead-ends; that state then sticks.
// Each hop takes a neighbour scan through the link table RAM (one read a
// cycle), one step and one result state, plus a direct-link read and check
// on the first search; a walk has at most 15 hops. One request is worked on
// at a time; the next item is taken as soon as the last result sits in the
// output register.
// Config writes (node_count, source, sink) are always ready and are meant to
// be issued while the block is idle.
// Reset clears all links (per-entry valid bits), used marks, path count and
// the exhausted flag at once; no clearing pass is needed.
// When the m side stalls, the walk holds in place with its result pending.
// ----------------------------------------------------------------------------
module greedy_best_link_path_select (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    input  logic [gbl_pkg::IN_DATA_W-1:0]     i_s_tdata,   // row_node, col_node, weight
    input  logic [0:0]                        i_s_tuser,   // func
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    output logic [gbl_pkg::OUT_DATA_W-1:0]    o_m_tdata,   // status, from_node, to_node, path_number
    output logic                              o_m_tlast,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [gbl_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [gbl_pkg::CFG_DAT_W-1:0]     i_cfg_data
);
    import gbl_pkg::*;

    t_cmd cmd;
    t_sts sts;

    assign o_cfg_ready = 1'b1;

    gbl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_func     (i_s_tuser[0]),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    gbl_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_row_node  (i_s_tdata[NODE_W-1:0]),
        .i_col_node  (i_s_tdata[2*NODE_W-1:NODE_W]),
        .i_weight    (i_s_tdata[2*NODE_W+WEIGHT_W-1:2*NODE_W]),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast)
    );

endmodule

/* bench/tb_greedy_best_link_path_select.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_greedy_best_link_path_select
// Self-checking bench for the greedy best-link path selector. A tracker class
// mirrors the link table, the used marks, the path counter and the exhausted
// flag. For every accepted item it works out the hop, acknowledge and
// no-more-paths items that must follow. Each output item is checked field by
// field against the oldest expected one. Directed items come first: ties,
// the direct link on a first search, sink equal to source, and source or sink
// out of range. Random phases follow under several register settings. Path
// requests are held back from dead ends until a closing phase builds one on
// purpose and then keeps sending into the stuck state.
// ----------------------------------------------------------------------------
module tb_greedy_best_link_path_select;
    import gbl_pkg::*;

    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_FIND  = 1'b1;
    localparam int   CYCLE_LIMIT = 2000000;
    localparam int   TAIL_CYCLES = MAX_NODES * (MAX_NODES + 6) + 50;
    localparam int   PHASE_ITEMS = 15;

    typedef struct {
        logic [STATUS_W-1:0] status;
        logic [NODE_W-1:0]   from_n;
        logic [NODE_W-1:0]   to_n;
        logic [PATH_W-1:0]   path_no;
        logic                last;
    } t_path_result;

    class t_path_tracker;
        logic [WEIGHT_W-1:0] link_w [TAB_DEPTH];
        bit                  marks [MAX_NODES];
        logic [PATH_W-1:0]   paths;
        bit                  exhausted;
        logic [CNT_W-1:0]    node_count;
        logic [NODE_W-1:0]   src;
        logic [NODE_W-1:0]   snk;
        t_path_result        results_due [$];
        int errors, writes, finds, hops, nomores, settings, wraps;

        function new();
            foreach (link_w[i]) link_w[i] = '0;
            foreach (marks[i]) marks[i] = 1'b0;
            paths = '0;
            exhausted = 1'b0;
            node_count = RST_NODE_COUNT;
            src = RST_SOURCE;
            snk = RST_SINK;
        endfunction

        task report(string what);
            errors++;
            if (errors <= 20)
                $display("mismatch: %s", what);
        endtask

        function int eff_nodes();
            return (node_count > MAX_NODES) ? MAX_NODES : int'(node_count);
        endfunction

        function int pending();
            return results_due.size();
        endfunction

        function t_path_result make_res(logic [STATUS_W-1:0] st, int f, int t,
                                        logic [PATH_W-1:0] p);
            t_path_result r;
            r.status = st;
            r.from_n = f[NODE_W-1:0];
            r.to_n = t[NODE_W-1:0];
            r.path_no = p;
            r.last = 1'b0;
            return r;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
            settings++;
            case (idx)
                CFG_NODE_COUNT: node_count = val;
                CFG_SOURCE:     src = val[NODE_W-1:0];
                CFG_SINK:       snk = val[NODE_W-1:0];
                default: ;
            endcase
        endfunction

        // greedy walk; returns 1 when it ends in a new dead end
        function bit walk_path(bit commit);
            bit                  lm [MAX_NODES];
            logic [PATH_W-1:0]   lp;
            bit                  le, first, dead, done;
            t_path_result        res [$];
            t_path_result        tail;
            int                  n, cur, b, i;
            logic [WEIGHT_W-1:0] top, w;
            lm = marks;
            lp = paths;
            le = exhausted;
            dead = 1'b0;
            done = 1'b0;
            n = eff_nodes();
            if (exhausted || src >= n || snk >= n) begin
                res.push_back(make_res(ST_NOMORE, 0, 0, lp));
            end else if (snk == src) begin
                res.push_back(make_res(ST_HOP, src, src, lp));
                lp++;
            end else begin
                first = !lm[snk];
                cur = snk;
                while (!done) begin
                    if (!first && cur == src) begin
                        lp++;
                        done = 1'b1;
                    end else if (res.size() >= HOP_LIMIT) begin
                        le = 1'b1;
                        dead = 1'b1;
                        res.push_back(make_res(ST_NOMORE, 0, 0, lp));
                        done = 1'b1;
                    end else if (first && link_w[cur * MAX_NODES + src] != 0) begin
                        res.push_back(make_res(ST_HOP, cur, src, lp));
                        lp++;
                        done = 1'b1;
                    end else begin
                        if (first)
                            lm[cur] = 1'b1;
                        b = -1;
                        top = '0;
                        for (i = 0; i < n; i++) begin
                            w = link_w[cur * MAX_NODES + i];
                            if (w != 0 && !lm[i] && w > top) begin
                                top = w;
                                b = i;
                            end
                        end
                        if (b < 0) begin
                            le = 1'b1;
                            dead = 1'b1;
                            res.push_back(make_res(ST_NOMORE, 0, 0, lp));
                            done = 1'b1;
                        end else begin
                            res.push_back(make_res(ST_HOP, cur, b, lp));
                            if (b != src)
                                lm[b] = 1'b1;
                            cur = b;
                        end
                    end
                end
            end
            tail = res.pop_back();
            tail.last = 1'b1;
            res.push_back(tail);
            if (commit) begin
                if (paths == 8'hFF && lp == 8'h00)
                    wraps++;
                marks = lm;
                paths = lp;
                exhausted = le;
                foreach (res[j]) results_due.push_back(res[j]);
            end
            return dead;
        endfunction

        function void note_item(logic f, logic [NODE_W-1:0] r, logic [NODE_W-1:0] c,
                                logic [WEIGHT_W-1:0] w);
            t_path_result ack;
            bit dead;
            if (f == FUNC_WRITE) begin
                writes++;
                link_w[r * MAX_NODES + c] = w;
                ack = make_res(ST_WACK, r, c, paths);
                ack.last = 1'b1;
                results_due.push_back(ack);
            end else begin
                finds++;
                dead = walk_path(1'b1);
            end
        endfunction

        task check_result(logic [OUT_DATA_W-1:0] d, logic l);
            t_path_result e;
            if (results_due.size() == 0) begin
                report($sformatf("unexpected item %h last %b", d, l));
                return;
            end
            e = results_due.pop_front();
            if (e.status == ST_HOP)
                hops++;
            else if (e.status == ST_NOMORE)
                nomores++;
            if (d[1:0] !== e.status)
                report($sformatf("status %0d, want %0d", d[1:0], e.status));
            if (d[5:2] !== e.from_n)
                report($sformatf("from_node %0d, want %0d", d[5:2], e.from_n));
            if (d[9:6] !== e.to_n)
                report($sformatf("to_node %0d, want %0d", d[9:6], e.to_n));
            if (d[17:10] !== e.path_no)
                report($sformatf("path_number %0d, want %0d", d[17:10], e.path_no));
            if (l !== e.last)
                report($sformatf("tlast %b, want %b", l, e.last));
        endtask

        function int pick_unmarked(int n, int ex1, int ex2);
            int q [$];
            int i;
            for (i = 0; i < n; i++)
                if (!marks[i] && i != ex1 && i != ex2)
                    q.push_back(i);
            return (q.size() != 0) ? q[$urandom_range(0, q.size() - 1)] : -1;
        endfunction

        // a marked source can only be reached again by a direct link on a first search, so prefer fresh ones
        function int choose_source(int pref, int n);
            int alt;
            if (pref < n && !marks[pref])
                return pref;
            alt = pick_unmarked(n, -1, -1);
            return (alt >= 0) ? alt : pref;
        endfunction

        function int row_missing_link();
            int q [$];
            int i;
            for (i = 0; i < eff_nodes(); i++)
                if (i != src && link_w[i * MAX_NODES + src] == 0)
                    q.push_back(i);
            return (q.size() != 0) ? q[$urandom_range(0, q.size() - 1)] : -1;
        endfunction
    endclass

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_s_tvalid = 1'b0;
    logic                   o_s_tready;
    logic [IN_DATA_W-1:0]   i_s_tdata = '0;   // row_node, col_node, weight
    logic [0:0]             i_s_tuser = '0;   // func
    logic                   o_m_tvalid;
    logic                   i_m_tready = 1'b0;
    logic [OUT_DATA_W-1:0]  o_m_tdata;        // status, from_node, to_node, path_number
    logic                   o_m_tlast;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [CFG_DAT_W-1:0]   i_cfg_data = '0;

    t_path_tracker tracker = new();
    int s_idle = 0;
    int m_idle = 0;

    greedy_best_link_path_select dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready)
            tracker.check_result(o_m_tdata, o_m_tlast);
        i_m_tready <= i_rst_n && ($urandom_range(0, 99) >= m_idle);
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("RESULT: ERROR");
        $finish;
    end

    task automatic send_item(logic f, logic [NODE_W-1:0] r, logic [NODE_W-1:0] c,
                             logic [WEIGHT_W-1:0] w);
        i_s_tvalid <= 1'b1;
        i_s_tuser <= f;
        i_s_tdata <= {w, c, r};
        do @(posedge i_clk); while (!o_s_tready);
        tracker.note_item(f, r, c, w);
        if ($urandom_range(0, 99) < s_idle) begin
            i_s_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < s_idle);
        end
    endtask

    task automatic drain();
        i_s_tvalid <= 1'b0;
        while (tracker.pending() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        tracker.set_reg(idx, val);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic new_setting(logic [CNT_W-1:0] nc, int so, int si);
        drain();
        write_reg(CFG_NODE_COUNT, nc);
        write_reg(CFG_SOURCE, CFG_DAT_W'(so));
        write_reg(CFG_SINK, CFG_DAT_W'(si));
    endtask

    function automatic logic [NODE_W-1:0] pick_node();
        if ($urandom_range(0, 99) < 80)
            return NODE_W'($urandom_range(0, tracker.eff_nodes() - 1));
        return NODE_W'($urandom_range(0, MAX_NODES - 1));
    endfunction

    function automatic logic [WEIGHT_W-1:0] pick_weight();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return 16'hFFFF;
            2: return WEIGHT_W'($urandom_range(1, 3));
            3: return 16'h8000;
            default: return WEIGHT_W'($urandom);
        endcase
    endfunction

    // path requests are steered clear of dead ends unless allowed
    task automatic random_item(bit allow_dead);
        int r;
        if ($urandom_range(0, 99) < 45) begin
            if (allow_dead || !tracker.walk_path(1'b0)) begin
                send_item(FUNC_FIND, NODE_W'($urandom), NODE_W'($urandom), WEIGHT_W'($urandom));
                return;
            end
            r = tracker.row_missing_link();
            if (r >= 0) begin
                send_item(FUNC_WRITE, NODE_W'(r), tracker.src,
                          WEIGHT_W'($urandom_range(1, 65535)));
                return;
            end
        end
        send_item(FUNC_WRITE, pick_node(), pick_node(), pick_weight());
    endtask

    task automatic run_phase(logic [CNT_W-1:0] nc, int so_pref, int si, int count);
        int so;
        so = tracker.choose_source(so_pref, (nc > MAX_NODES) ? MAX_NODES : int'(nc));
        new_setting(nc, so, si);
        repeat (count) random_item(1'b0);
    endtask

    initial begin
        int a, b, i;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        s_idle = 31;
        m_idle = 64;

        // equal weights out of node 1, lowest index wins
        send_item(FUNC_WRITE, 4'd0, 4'd0, 16'h0000);
        send_item(FUNC_WRITE, 4'd15, 4'd15, 16'hFFFF);
        send_item(FUNC_WRITE, 4'd1, 4'd2, 16'h0100);
        send_item(FUNC_WRITE, 4'd1, 4'd3, 16'h0100);
        send_item(FUNC_WRITE, 4'd2, 4'd4, 16'h8000);
        send_item(FUNC_WRITE, 4'd4, 4'd0, 16'hFFFF);
        send_item(FUNC_FIND, 4'd0, 4'd0, 16'h0000);
        send_item(FUNC_WRITE, 4'd3, 4'd0, 16'h0001);
        send_item(FUNC_FIND, 4'd15, 4'd15, 16'hFFFF);
        // direct link on a first search
        send_item(FUNC_WRITE, 4'd5, 4'd0, 16'h0200);
        new_setting(5'd16, 0, 5);
        send_item(FUNC_FIND, 4'd0, 4'd0, 16'h0000);
        // sink equal to source
        new_setting(5'd16, 0, 0);
        send_item(FUNC_FIND, 4'd0, 4'd0, 16'h0000);
        // source, then sink, outside the nodes in use
        new_setting(5'd2, 3, 1);
        send_item(FUNC_FIND, 4'd0, 4'd0, 16'h0000);
        new_setting(5'd2, 0, 5);
        send_item(FUNC_FIND, 4'd0, 4'd0, 16'h0000);
        // node count above the table size
        new_setting(5'd31, 15, 15);
        send_item(FUNC_FIND, 4'd0, 4'd0, 16'h0000);
        new_setting(5'd16, 0, 1);
        send_item(FUNC_WRITE, 4'd1, 4'd0, 16'h00FF);
        send_item(FUNC_FIND, 4'd0, 4'd0, 16'h0000);

        run_phase(5'd2, 1, 0, PHASE_ITEMS);
        run_phase(5'd8, 7, 2, PHASE_ITEMS);
        s_idle = 64;
        m_idle = 31;
        run_phase(5'd12, $urandom_range(0, 15), $urandom_range(0, 15), PHASE_ITEMS);
        run_phase(5'd31, 15, 14, PHASE_ITEMS);

        // self paths until the path counter wraps
        new_setting(5'd31, tracker.src, tracker.src);
        do send_item(FUNC_FIND, NODE_W'($urandom), NODE_W'($urandom), WEIGHT_W'($urandom));
        while (tracker.paths != 0);

        s_idle = 0;
        m_idle = 0;
        run_phase(5'd16, $urandom_range(0, 15), 15, PHASE_ITEMS);
        run_phase(5'd5, $urandom_range(0, 15), $urandom_range(0, 15), PHASE_ITEMS);

        // build a dead end from a fresh sink, then keep going in the stuck state
        new_setting(5'd16, tracker.src, tracker.snk);
        a = tracker.pick_unmarked(MAX_NODES, tracker.src, tracker.src);
        if (a < 0)
            a = (tracker.src + 1) % MAX_NODES;
        b = tracker.pick_unmarked(MAX_NODES, tracker.src, a);
        if (b < 0) begin
            b = (a + 1) % MAX_NODES;
            if (b == tracker.src)
                b = (b + 1) % MAX_NODES;
        end
        for (i = 0; i < MAX_NODES; i++) begin
            send_item(FUNC_WRITE, NODE_W'(a), NODE_W'(i), '0);
            send_item(FUNC_WRITE, NODE_W'(b), NODE_W'(i), '0);
        end
        send_item(FUNC_WRITE, NODE_W'(a), NODE_W'(b), WEIGHT_W'($urandom_range(1, 65535)));
        new_setting(5'd16, tracker.src, a);
        send_item(FUNC_FIND, NODE_W'($urandom), NODE_W'($urandom), WEIGHT_W'($urandom));
        repeat (16) random_item(1'b1);

        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("covered %0d weight writes and %0d path requests over %0d register writes",
                 tracker.writes, tracker.finds, tracker.settings);
        $display("saw %0d hops and %0d no-more-path items, path counter wrapped %0d time(s)",
                 tracker.hops, tracker.nomores, tracker.wraps);
        if (tracker.errors == 0 && tracker.pending() == 0) begin
            $display("RESULT: OK");
        end else begin
            if (tracker.pending() != 0)
                $display("%0d expected items never arrived", tracker.pending());
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
